/* rtl/block_histogram_range_add_count_assert.svh */
// assertion macros for the block histogram range add count design
`ifndef BLOCK_HISTOGRAM_RANGE_ADD_COUNT_ASSERT_SVH
`define BLOCK_HISTOGRAM_RANGE_ADD_COUNT_ASSERT_SVH
`ifndef SYNTHESIS
`define BHR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define BHR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BHR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BHR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/bhr_pkg.sv */
// shared constants and types for the block histogram range add count design
package bhr_pkg;
  localparam int unsigned BlockSizeDef  = 32;
  localparam int unsigned NumBlocksDef  = 32;
  localparam int unsigned ValueLimitDef = 1024;
  localparam int unsigned IdxW          = 10;
  localparam int unsigned AmtW          = 32;
  localparam int unsigned CntW          = 11;

  typedef enum logic [1:0] {
    OpWrite = 2'd0,
    OpAdd   = 2'd1,
    OpCount = 2'd2,
    OpNone  = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]        operation;
    logic [IdxW-1:0]   left_index;
    logic [IdxW-1:0]   right_index;
    logic signed [AmtW-1:0] amount;
  } req_t;

  typedef struct packed {
    logic [CntW-1:0] match_count;
    logic            found;
    logic            range_overflow;
  } rsp_t;
endpackage

/* rtl/bhr_if.sv */
// valid/ready channel interfaces for requests and results
interface bhr_req_if;
  import bhr_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bhr_rsp_if;
  import bhr_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/block_histogram_range_add_count.sv */
// top level: block decomposed array with lazy offsets and per-block histograms
// flow: a write updates its element's base and histogram; add/count walk partial elements
//   one by one (add: base and histogram, count: compare) and whole blocks one at a time
//   (add: block offset, count: histogram bin read), then send the result word
// throughput: one word at a time, next word taken once the result word has left
// reset: clearing pass over the histogram ram, bases and offsets cleared within it
module block_histogram_range_add_count #(
  parameter int unsigned BlockSize  = bhr_pkg::BlockSizeDef,
  parameter int unsigned NumBlocks  = bhr_pkg::NumBlocksDef,
  parameter int unsigned ValueLimit = bhr_pkg::ValueLimitDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bhr_req_if.sink   req_i,
  bhr_rsp_if.source rsp_o
);
  import bhr_pkg::*;
  `include "block_histogram_range_add_count_assert.svh"

  localparam int unsigned Total = BlockSize * NumBlocks;
  localparam int unsigned BW    = (NumBlocks > 1) ? $clog2(NumBlocks) : 1;
  localparam int unsigned OW    = $clog2(BlockSize);
  localparam int unsigned EW    = (Total > 1) ? $clog2(Total) : 1;
  localparam int unsigned VW    = $clog2(ValueLimit);
  localparam int unsigned HW    = $clog2(NumBlocks * ValueLimit);
  localparam int unsigned HCW   = $clog2(BlockSize + 1);
  localparam int unsigned XW    = (EW > IdxW ? EW : IdxW) + 2;

  // sequencer states
  localparam logic [3:0] StClear = 4'd0;
  localparam logic [3:0] StIdle  = 4'd1;
  localparam logic [3:0] StStep  = 4'd2;  // decide next element or block
  localparam logic [3:0] StRd    = 4'd3;  // base / offset read issued
  localparam logic [3:0] StCalc  = 4'd4;  // data back, compute
  localparam logic [3:0] StHdec  = 4'd5;  // read old histogram bin
  localparam logic [3:0] StHdecW = 4'd6;
  localparam logic [3:0] StHinc  = 4'd7;
  localparam logic [3:0] StHincW = 4'd8;
  localparam logic [3:0] StHcnt  = 4'd9;  // whole block histogram read
  localparam logic [3:0] StHcntW = 4'd10;
  localparam logic [3:0] StOut   = 4'd11;

  logic [3:0] st_q, st_d;
  req_t req_q, req_d;
  logic [XW-1:0] i_q, i_d, r_q, r_d;
  logic [HW-1:0] clr_q, clr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic ovf_q, ovf_d;
  logic [VW-1:0] old_q, old_d, new_q, new_d;
  logic rsp_valid_q, rsp_valid_d;
  rsp_t rsp_q, rsp_d;

  // memories
  logic          b_we, h_we, o_we;
  logic [EW-1:0] b_addr;
  logic [VW-1:0] b_wdata, b_rdata;
  logic [HW-1:0] h_addr;
  logic [HCW-1:0] h_wdata, h_rdata;
  logic [BW-1:0] o_addr;
  logic [AmtW-1:0] o_wdata, o_rdata;

  bhr_ram #(.Width(VW), .Depth(Total)) u_base (
    .clk_i, .we_i(b_we), .addr_i(b_addr), .wdata_i(b_wdata), .rdata_o(b_rdata));
  bhr_ram #(.Width(HCW), .Depth(NumBlocks * ValueLimit)) u_hist (
    .clk_i, .we_i(h_we), .addr_i(h_addr), .wdata_i(h_wdata), .rdata_o(h_rdata));
  bhr_ram #(.Width(AmtW), .Depth(NumBlocks)) u_off (
    .clk_i, .we_i(o_we), .addr_i(o_addr), .wdata_i(o_wdata), .rdata_o(o_rdata));

  // current element, its block and position in block
  logic [EW-1:0] i_e;
  logic [BW-1:0] blk;
  logic [OW-1:0] pos;
  logic          whole;
  logic signed [AmtW+1:0] want, tgt;

  assign i_e   = i_q[EW-1:0];
  assign blk   = (NumBlocks > 1) ? BW'(i_e >> OW) : '0;
  assign pos   = i_e[OW-1:0];
  assign whole = (pos == '0) && ((i_q + XW'(BlockSize - 1)) <= r_q)
                 && (req_q.operation != OpWrite);

  always_comb begin
    st_d = st_q; req_d = req_q; i_d = i_q; r_d = r_q; clr_d = clr_q;
    cnt_d = cnt_q; ovf_d = ovf_q; old_d = old_q; new_d = new_q;
    rsp_valid_d = rsp_valid_q; rsp_d = rsp_q;
    b_we = 1'b0; h_we = 1'b0; o_we = 1'b0;
    b_addr = i_e; b_wdata = new_q;
    h_addr = HW'({blk, old_q}); h_wdata = '0;
    o_addr = blk; o_wdata = o_rdata + req_q.amount;
    want = '0; tgt = '0;
    req_i.ready = 1'b0;
    if (rsp_valid_q && rsp_o.ready) rsp_valid_d = 1'b0;
    case (st_q)
      StClear: begin
        h_we = 1'b1; h_addr = clr_q;
        h_wdata = (clr_q[VW-1:0] == '0) ? HCW'(BlockSize) : '0;
        b_we = (clr_q < HW'(Total)); b_addr = clr_q[EW-1:0]; b_wdata = '0;
        o_we = (clr_q < HW'(NumBlocks)); o_addr = clr_q[BW-1:0]; o_wdata = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == HW'(NumBlocks * ValueLimit - 1)) st_d = StIdle;
      end
      StIdle: begin
        req_i.ready = !rsp_valid_q;
        if (req_i.valid && !rsp_valid_q) begin
          req_d = req_i.data;
          i_d = XW'(req_i.data.left_index);
          r_d = (XW'(req_i.data.right_index) > XW'(Total - 1))
                ? XW'(Total - 1) : XW'(req_i.data.right_index);
          if (req_i.data.operation == OpWrite) r_d = XW'(req_i.data.left_index);
          cnt_d = '0; ovf_d = 1'b0;
          st_d = (req_i.data.operation == OpNone) ? StOut : StStep;
        end
      end
      StStep: begin
        if (i_q > r_q || i_q >= XW'(Total)) st_d = StOut;
        else st_d = StRd;
      end
      StRd: st_d = StCalc;  // rams read at i/blk this cycle
      StCalc: begin
        old_d = b_rdata;
        if (whole) begin
          if (req_q.operation == OpAdd) begin
            o_we = 1'b1; i_d = i_q + XW'(BlockSize); st_d = StStep;
          end else begin
            tgt = (AmtW+2)'(req_q.amount) - (AmtW+2)'($signed(o_rdata));
            // bin read keeps i on this block until the count is in
            if (tgt >= 0 && tgt < (AmtW+2)'(ValueLimit)) begin
              old_d = tgt[VW-1:0]; st_d = StHcnt;
            end else begin
              i_d = i_q + XW'(BlockSize); st_d = StStep;
            end
          end
        end else if (req_q.operation == OpCount) begin
          if ((AmtW+2)'({1'b0, b_rdata}) + (AmtW+2)'($signed(o_rdata))
              == (AmtW+2)'(req_q.amount)) cnt_d = cnt_q + 1'b1;
          i_d = i_q + 1'b1; st_d = StStep;
        end else begin
          if (req_q.operation == OpWrite)
            want = (AmtW+2)'(req_q.amount) - (AmtW+2)'($signed(o_rdata));
          else
            want = (AmtW+2)'({1'b0, b_rdata}) + (AmtW+2)'(req_q.amount);
          if (want < 0) begin new_d = '0; ovf_d = 1'b1; end
          else if (want > (AmtW+2)'(ValueLimit - 1)) begin
            new_d = VW'(ValueLimit - 1); ovf_d = 1'b1;
          end else new_d = want[VW-1:0];
          st_d = StHdec;
        end
      end
      StHdec: st_d = StHdecW;
      StHdecW: begin
        h_we = 1'b1; h_wdata = h_rdata - 1'b1;
        b_we = 1'b1; old_d = new_q; st_d = StHinc;
      end
      StHinc: st_d = StHincW;
      StHincW: begin
        h_we = 1'b1; h_wdata = h_rdata + 1'b1;
        i_d = i_q + 1'b1; st_d = StStep;
      end
      StHcnt: st_d = StHcntW;
      StHcntW: begin
        cnt_d = cnt_q + CntW'(h_rdata);
        i_d = i_q + XW'(BlockSize); st_d = StStep;
      end
      StOut: begin
        rsp_valid_d = 1'b1;
        rsp_d.match_count = cnt_q;
        rsp_d.found = (cnt_q != '0);
        rsp_d.range_overflow = ovf_q;
        st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StClear; clr_q <= '0; rsp_valid_q <= 1'b0;
    end else begin
      st_q <= st_d; clr_q <= clr_d; rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d; i_q <= i_d; r_q <= r_d; cnt_q <= cnt_d; ovf_q <= ovf_d;
    old_q <= old_d; new_q <= new_d; rsp_q <= rsp_d;
  end

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  // result word waits until taken
  `BHR_ASSERT_IMP(a_no_accept_busy, clk_i, rst_ni, st_q != StIdle, !req_i.ready)
  `BHR_ASSERT_NEXT(a_out_valid, clk_i, rst_ni, st_q == StOut, rsp_valid_q)
  `BHR_ASSERT_IMP(a_found, clk_i, rst_ni, rsp_valid_q, rsp_q.found == (rsp_q.match_count != '0))
  `BHR_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_q && !rsp_o.ready, rsp_valid_q)
endmodule

/* rtl/bhr_ram.sv */
// generic single port ram with registered read
module bhr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
